@@ design/pmhq_pkg.sv @@
// Shared types, constants and helpers of the point min-heap queue.
package pmhq_pkg;

  // Heap capacity and the widths that follow from it.
  localparam int unsigned HEAP_DEPTH  = 1024;
  localparam int unsigned ADDR_W      = $clog2(HEAP_DEPTH);
  localparam int unsigned CNT_W       = $clog2(HEAP_DEPTH + 1);
  localparam int unsigned LINK_W      = ADDR_W + 1;

  // Fixed field widths of the channels.
  localparam int unsigned COORD_W     = 32;
  localparam int unsigned ENTRY_W     = 2 * COORD_W;
  localparam int unsigned COUNT_OUT_W = 11;

  typedef logic [ENTRY_W-1:0]     entry_t;
  typedef logic [ADDR_W-1:0]      addr_t;
  typedef logic [CNT_W-1:0]       cnt_t;
  typedef logic [LINK_W-1:0]      link_t;
  typedef logic [COUNT_OUT_W-1:0] count_out_t;

  // Flipping the sign bit of each half turns the signed (x, y) order into
  // a plain unsigned compare of the whole entry.
  localparam entry_t KEY_FLIP = {1'b1, {(COORD_W-1){1'b0}}, 1'b1, {(COORD_W-1){1'b0}}};

  typedef enum logic {
    FUNC_INSERT  = 1'b0,
    FUNC_EXTRACT = 1'b1
  } func_e;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  // One access cycle of the heap memory.
  typedef struct packed {
    logic   we;
    addr_t  waddr;
    entry_t wdata;
    logic   re;
    addr_t  raddr;
  } mem_req_t;

  // Finished result handed from the sift engine to the output stage.
  typedef struct packed {
    logic       valid;
    entry_t     result;
    status_e    status;
    count_out_t count;
    entry_t     minimum;
  } rsp_t;

  // Lexicographic signed order of two entries, x in the upper half.
  function automatic logic less_than(entry_t a, entry_t b);
    return (a ^ KEY_FLIP) < (b ^ KEY_FLIP);
  endfunction

endpackage

@@ design/pmhq_chan_if.sv @@
// Valid/ready channel interfaces for request and result beats.
interface pmhq_in_if;
  logic               valid;
  logic               ready;
  logic               func;
  logic signed [31:0] point_x;
  logic signed [31:0] point_y;

  modport source (output valid, output func, output point_x, output point_y, input ready);
  modport sink   (input valid, input func, input point_x, input point_y, output ready);
endinterface

interface pmhq_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] result_x;
  logic signed [31:0] result_y;
  logic        [1:0]  status;
  logic        [10:0] entry_count;
  logic signed [31:0] min_x;
  logic signed [31:0] min_y;

  modport source (output valid, output result_x, output result_y, output status,
                  output entry_count, output min_x, output min_y, input ready);
  modport sink   (input valid, input result_x, input result_y, input status,
                  input entry_count, input min_x, input min_y, output ready);
endinterface

@@ design/pmhq_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read data.
module pmhq_ram #(
  parameter int unsigned Width = 64,
  parameter int unsigned Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port, with registered read data.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ design/pmhq_sift.sv @@
// Sift engine: runs insert and extract operations against the heap memory.
module pmhq_sift (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  pmhq_pkg::func_e    in_func_i,
  input  pmhq_pkg::entry_t   in_point_i,
  output logic               in_ready_o,
  output pmhq_pkg::mem_req_t mem_req_o,
  input  pmhq_pkg::entry_t   mem_rdata_i,
  output pmhq_pkg::rsp_t     rsp_o,
  input  logic               rsp_ready_i
);

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_LAST   = 8'b0000_0010,
    S_UP     = 8'b0000_0100,
    S_UP_CMP = 8'b0000_1000,
    S_DN     = 8'b0001_0000,
    S_DN_L   = 8'b0010_0000,
    S_DN_R   = 8'b0100_0000,
    S_DONE   = 8'b1000_0000
  } state_e;

  state_e             state_q, state_d;
  pmhq_pkg::cnt_t     cnt_q, cnt_d;
  pmhq_pkg::entry_t   cur_q, cur_d;
  pmhq_pkg::addr_t    pos_q, pos_d;
  pmhq_pkg::entry_t   best_q, best_d;
  pmhq_pkg::addr_t    bidx_q, bidx_d;
  logic               moved_q, moved_d;
  pmhq_pkg::entry_t   min_q, min_d;
  pmhq_pkg::entry_t   res_q, res_d;
  pmhq_pkg::status_e  status_q, status_d;
  pmhq_pkg::mem_req_t mem_req;

  logic               is_full;
  pmhq_pkg::addr_t    parent;
  pmhq_pkg::link_t    left_l, right_l, cnt_l;
  pmhq_pkg::entry_t   cand_val, fin_val;
  pmhq_pkg::addr_t    cand_idx, child_idx, fin_idx;
  logic               cand_moved, child_lt, fin_moved;

  // Tree links of the current position.
  assign is_full = (cnt_q == pmhq_pkg::cnt_t'(pmhq_pkg::HEAP_DEPTH));
  assign parent  = (pos_q - pmhq_pkg::addr_t'(1)) >> 1;
  assign left_l  = {pos_q, 1'b1};
  assign right_l = left_l + pmhq_pkg::link_t'(1);
  assign cnt_l   = pmhq_pkg::link_t'(cnt_q);

  // Best of the moving entry and the child just read; the right child must be
  // strictly smaller than the running best, so equal children favor the left.
  always_comb begin
    if (state_q == S_DN_R) begin
      cand_val   = best_q;
      cand_idx   = bidx_q;
      cand_moved = moved_q;
      child_idx  = right_l[pmhq_pkg::ADDR_W-1:0];
    end else begin
      cand_val   = cur_q;
      cand_idx   = pos_q;
      cand_moved = 1'b0;
      child_idx  = left_l[pmhq_pkg::ADDR_W-1:0];
    end
    child_lt  = pmhq_pkg::less_than(mem_rdata_i, cand_val);
    fin_val   = child_lt ? mem_rdata_i : cand_val;
    fin_idx   = child_lt ? child_idx : cand_idx;
    fin_moved = child_lt | cand_moved;
  end

  // Operation sequencer.
  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    cur_d    = cur_q;
    pos_d    = pos_q;
    best_d   = best_q;
    bidx_d   = bidx_q;
    moved_d  = moved_q;
    res_d    = res_q;
    status_d = status_q;
    mem_req  = '0;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          res_d    = '0;
          status_d = pmhq_pkg::ST_DONE;
          if (in_func_i == pmhq_pkg::FUNC_INSERT) begin
            if (is_full) begin
              status_d = pmhq_pkg::ST_FULL;
              state_d  = S_DONE;
            end else begin
              cur_d   = in_point_i;
              pos_d   = pmhq_pkg::addr_t'(cnt_q);
              cnt_d   = cnt_q + pmhq_pkg::cnt_t'(1);
              state_d = S_UP;
            end
          end else if (cnt_q == '0) begin
            status_d = pmhq_pkg::ST_EMPTY;
            state_d  = S_DONE;
          end else begin
            res_d = min_q;
            cnt_d = cnt_q - pmhq_pkg::cnt_t'(1);
            pos_d = '0;
            if (cnt_q == pmhq_pkg::cnt_t'(1)) begin
              state_d = S_DONE;
            end else begin
              mem_req.re    = 1'b1;
              mem_req.raddr = pmhq_pkg::addr_t'(cnt_q - pmhq_pkg::cnt_t'(1));
              state_d       = S_LAST;
            end
          end
        end
      end
      S_LAST: begin
        cur_d   = mem_rdata_i;
        state_d = S_DN;
      end
      S_UP: begin
        if (pos_q == '0) begin
          mem_req.we    = 1'b1;
          mem_req.waddr = '0;
          mem_req.wdata = cur_q;
          state_d       = S_DONE;
        end else begin
          mem_req.re    = 1'b1;
          mem_req.raddr = parent;
          bidx_d        = parent;
          state_d       = S_UP_CMP;
        end
      end
      S_UP_CMP: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = pos_q;
        if (pmhq_pkg::less_than(cur_q, mem_rdata_i)) begin
          mem_req.wdata = mem_rdata_i;
          pos_d         = bidx_q;
          state_d       = S_UP;
        end else begin
          mem_req.wdata = cur_q;
          state_d       = S_DONE;
        end
      end
      S_DN: begin
        if (left_l >= cnt_l) begin
          mem_req.we    = 1'b1;
          mem_req.waddr = pos_q;
          mem_req.wdata = cur_q;
          state_d       = S_DONE;
        end else begin
          mem_req.re    = 1'b1;
          mem_req.raddr = left_l[pmhq_pkg::ADDR_W-1:0];
          state_d       = S_DN_L;
        end
      end
      S_DN_L, S_DN_R: begin
        if (state_q == S_DN_L && right_l < cnt_l) begin
          mem_req.re    = 1'b1;
          mem_req.raddr = right_l[pmhq_pkg::ADDR_W-1:0];
          best_d        = fin_val;
          bidx_d        = fin_idx;
          moved_d       = fin_moved;
          state_d       = S_DN_R;
        end else begin
          mem_req.we    = 1'b1;
          mem_req.waddr = pos_q;
          if (fin_moved) begin
            mem_req.wdata = fin_val;
            pos_d         = fin_idx;
            state_d       = S_DN;
          end else begin
            mem_req.wdata = cur_q;
            state_d       = S_DONE;
          end
        end
      end
      S_DONE: begin
        if (rsp_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // The root is mirrored in a register so the minimum needs no extra read.
  assign min_d = (mem_req.we && mem_req.waddr == '0) ? mem_req.wdata : min_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q    <= cur_d;
    pos_q    <= pos_d;
    best_q   <= best_d;
    bidx_q   <= bidx_d;
    moved_q  <= moved_d;
    min_q    <= min_d;
    res_q    <= res_d;
    status_q <= status_d;
  end

  assign in_ready_o    = (state_q == S_IDLE);
  assign mem_req_o     = mem_req;
  assign rsp_o.valid   = (state_q == S_DONE);
  assign rsp_o.result  = res_q;
  assign rsp_o.status  = status_q;
  assign rsp_o.count   = pmhq_pkg::count_out_t'(cnt_q);
  assign rsp_o.minimum = (cnt_q == '0) ? '0 : min_q;

  // A read never targets the entry written in the same cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mem_req.we && mem_req.re) |-> (mem_req.waddr != mem_req.raddr))
    else $error("heap memory read and write collide on one entry");

  // The count never exceeds the capacity.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= pmhq_pkg::cnt_t'(pmhq_pkg::HEAP_DEPTH))
    else $error("heap count above capacity");

  // The count only moves when a request beat is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |=> $stable(cnt_q))
    else $error("heap count changed during a sift");

endmodule

@@ design/point_min_heap_queue.sv @@
// Top level of the point min-heap queue: sift engine, heap memory, output stage.
//
// Each request beat is an insert or an extract-min of a signed (x, y) point,
// ordered by x and then y, and produces one result beat with the extracted
// point, a status, the entry count and the current minimum. One operation is
// in flight at a time; the heap memory has a single read port with registered
// read data, and that port sets the pace. An insert reads the parent and
// decides once per level the point climbs; an extract reads the left child,
// reads the right child and decides once per level descended. A finished
// result waits in an output register, so the next request beat is taken while
// it is unread. No clearing pass is needed after reset: only entries below the
// count are read.
module point_min_heap_queue (
  input  logic       clk_i,
  input  logic       rst_ni,
  pmhq_in_if.sink    in_ch_i,
  pmhq_out_if.source out_ch_o
);

  pmhq_pkg::mem_req_t mem_req;
  pmhq_pkg::entry_t   mem_rdata;
  pmhq_pkg::rsp_t     rsp;
  logic               rsp_ready;
  logic               out_valid_q, out_valid_d;
  pmhq_pkg::rsp_t     out_q;
  logic               load;

  pmhq_sift u_sift (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_ch_i.valid),
    .in_func_i   (pmhq_pkg::func_e'(in_ch_i.func)),
    .in_point_i  ({in_ch_i.point_x, in_ch_i.point_y}),
    .in_ready_o  (in_ch_i.ready),
    .mem_req_o   (mem_req),
    .mem_rdata_i (mem_rdata),
    .rsp_o       (rsp),
    .rsp_ready_i (rsp_ready)
  );

  pmhq_ram #(
    .Width (pmhq_pkg::ENTRY_W),
    .Depth (pmhq_pkg::HEAP_DEPTH)
  ) u_heap_ram (
    .clk_i   (clk_i),
    .we_i    (mem_req.we),
    .waddr_i (mem_req.waddr),
    .wdata_i (mem_req.wdata),
    .re_i    (mem_req.re),
    .raddr_i (mem_req.raddr),
    .rdata_o (mem_rdata)
  );

  // Output register: takes a result whenever the slot is free or being read.
  assign rsp_ready   = !out_valid_q || out_ch_o.ready;
  assign load        = rsp.valid && rsp_ready;
  assign out_valid_d = load || (out_valid_q && !out_ch_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_q <= rsp;
    end
  end

  assign out_ch_o.valid       = out_valid_q;
  assign out_ch_o.result_x    = out_q.result[pmhq_pkg::ENTRY_W-1:pmhq_pkg::COORD_W];
  assign out_ch_o.result_y    = out_q.result[pmhq_pkg::COORD_W-1:0];
  assign out_ch_o.status      = out_q.status;
  assign out_ch_o.entry_count = out_q.count;
  assign out_ch_o.min_x       = out_q.minimum[pmhq_pkg::ENTRY_W-1:pmhq_pkg::COORD_W];
  assign out_ch_o.min_y       = out_q.minimum[pmhq_pkg::COORD_W-1:0];

  // A rejected insert only happens with the heap full.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.status == pmhq_pkg::ST_FULL)
      |-> (out_q.count == pmhq_pkg::count_out_t'(pmhq_pkg::HEAP_DEPTH)))
    else $error("full status with heap not full");

  // An empty extract leaves the heap empty with a zero minimum.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.status == pmhq_pkg::ST_EMPTY)
      |-> (out_q.count == '0 && out_q.minimum == '0))
    else $error("empty status with entries held");

  // Failed operations never return a point.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.status != pmhq_pkg::ST_DONE) |-> (out_q.result == '0))
    else $error("failed operation returned a point");

endmodule

@@ tb/pmhq_heap_checker.sv @@
// Scoreboard for the point min-heap queue: a shadow heap predicts every result beat.
module pmhq_heap_checker
  import pmhq_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  pmhq_in_if          in_ch_i,
  pmhq_out_if         out_ch_i,
  output int unsigned mismatch_count_o,
  output int unsigned results_owed_o
);
  timeunit 1ns;
  timeprecision 1ps;

  // One predicted result beat.
  typedef struct {
    logic signed [COORD_W-1:0] taken_x;
    logic signed [COORD_W-1:0] taken_y;
    status_e                   status;
    count_out_t                count;
    logic signed [COORD_W-1:0] top_x;
    logic signed [COORD_W-1:0] top_y;
  } heap_outcome_t;

  // Shadow copy of the heap contents and fill level.
  entry_t        shadow_heap [HEAP_DEPTH];
  int unsigned   shadow_count;
  heap_outcome_t pending_outcomes [$];

  // Points order by signed x first, then by signed y.
  function automatic bit point_before(entry_t a, entry_t b);
    logic signed [COORD_W-1:0] ax, ay, bx, by;
    ax = a[ENTRY_W-1:COORD_W];
    ay = a[COORD_W-1:0];
    bx = b[ENTRY_W-1:COORD_W];
    by = b[COORD_W-1:0];
    if (ax != bx) return ax < bx;
    return ay < by;
  endfunction

  function automatic void swap_slots(int unsigned i, int unsigned j);
    entry_t held;
    held           = shadow_heap[i];
    shadow_heap[i] = shadow_heap[j];
    shadow_heap[j] = held;
  endfunction

  // Applies one operation to the shadow heap and returns the beat it must produce.
  function automatic heap_outcome_t apply_operation(logic op, logic signed [COORD_W-1:0] px,
                                                    logic signed [COORD_W-1:0] py);
    heap_outcome_t outcome;
    int unsigned   pos, parent, left, right, best;
    bit            moving;
    entry_t        taken;
    entry_t        top;
    taken  = '0;
    outcome.status = ST_DONE;
    if (op == FUNC_INSERT) begin
      if (shadow_count >= HEAP_DEPTH) begin
        outcome.status = ST_FULL;
      end else begin
        // Append at the end and climb while strictly below the parent.
        pos              = shadow_count;
        shadow_heap[pos] = {px, py};
        shadow_count++;
        moving = 1'b1;
        while (moving && pos > 0) begin
          parent = (pos - 1) / 2;
          if (point_before(shadow_heap[pos], shadow_heap[parent])) begin
            swap_slots(pos, parent);
            pos = parent;
          end else begin
            moving = 1'b0;
          end
        end
      end
    end else begin
      if (shadow_count == 0) begin
        outcome.status = ST_EMPTY;
      end else begin
        // Take the root, move the last entry up and let it sink.
        taken          = shadow_heap[0];
        shadow_heap[0] = shadow_heap[shadow_count-1];
        shadow_count--;
        pos    = 0;
        moving = 1'b1;
        while (moving) begin
          left  = 2 * pos + 1;
          right = left + 1;
          best  = pos;
          if (left < shadow_count && point_before(shadow_heap[left], shadow_heap[best]))
            best = left;
          if (right < shadow_count && point_before(shadow_heap[right], shadow_heap[best]))
            best = right;
          if (best == pos) begin
            moving = 1'b0;
          end else begin
            swap_slots(pos, best);
            pos = best;
          end
        end
      end
    end
    top = (shadow_count > 0) ? shadow_heap[0] : '0;
    outcome.taken_x = taken[ENTRY_W-1:COORD_W];
    outcome.taken_y = taken[COORD_W-1:0];
    outcome.count   = count_out_t'(shadow_count);
    outcome.top_x   = top[ENTRY_W-1:COORD_W];
    outcome.top_y   = top[COORD_W-1:0];
    return outcome;
  endfunction

  task automatic check_field(string field, logic [COORD_W-1:0] want, logic [COORD_W-1:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, field, want, got);
      mismatch_count_o++;
    end
  endtask

  // Predict on every request beat, then compare every result beat with the oldest prediction.
  always @(posedge clk_i or negedge rst_ni) begin : scoreboard
    heap_outcome_t want;
    if (!rst_ni) begin
      shadow_count     = 0;
      pending_outcomes.delete();
      mismatch_count_o = 0;
      results_owed_o   = 0;
    end else begin
      if (in_ch_i.valid && in_ch_i.ready) begin
        pending_outcomes.push_back(
          apply_operation(in_ch_i.func, in_ch_i.point_x, in_ch_i.point_y));
      end
      if (out_ch_i.valid && out_ch_i.ready) begin
        if (pending_outcomes.size() == 0) begin
          $display("%0t: result beat with no request outstanding", $time);
          mismatch_count_o++;
        end else begin
          want = pending_outcomes.pop_front();
          check_field("result_x", want.taken_x, out_ch_i.result_x);
          check_field("result_y", want.taken_y, out_ch_i.result_y);
          check_field("status", COORD_W'(want.status), COORD_W'(out_ch_i.status));
          check_field("entry_count", COORD_W'(want.count), COORD_W'(out_ch_i.entry_count));
          check_field("min_x", want.top_x, out_ch_i.min_x);
          check_field("min_y", want.top_y, out_ch_i.min_y);
        end
      end
      results_owed_o = pending_outcomes.size();
    end
  end

endmodule

@@ tb/tb_point_min_heap_queue.sv @@
// Top of the point min-heap queue testbench: clock, reset, request and result traffic, verdict.
module tb_point_min_heap_queue;
  timeunit 1ns;
  timeprecision 1ps;
  import pmhq_pkg::*;

  localparam logic signed [COORD_W-1:0] COORD_MIN = 32'sh8000_0000;
  localparam logic signed [COORD_W-1:0] COORD_MAX = 32'sh7FFF_FFFF;

  logic        clk_i;
  logic        rst_ni;
  int unsigned mismatch_count;
  int unsigned results_owed;
  int unsigned heap_fill;
  int unsigned send_burst;
  int unsigned sink_burst;

  pmhq_in_if  in_ch ();
  pmhq_out_if out_ch ();

  point_min_heap_queue i_dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_ch_i  (in_ch),
    .out_ch_o (out_ch)
  );

  pmhq_heap_checker i_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_ch_i          (in_ch),
    .out_ch_i         (out_ch),
    .mismatch_count_o (mismatch_count),
    .results_owed_o   (results_owed)
  );

  // The clock starts low so that the first rising edge falls inside reset.
  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // Safety net against a hung handshake.
  initial begin
    #10_000_000;
    $display("Test completed with failures");
    $finish;
  end

  // Idle cycles before a beat; now and then a run of back-to-back beats.
  function automatic int unsigned draw_gap(inout int unsigned burst_left);
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    if ($urandom_range(0, 31) == 0) burst_left = $urandom_range(20, 60);
    return $urandom_range(0, 16);
  endfunction

  // Coordinates lean toward small values and extremes so that ties and sign flips are common.
  function automatic logic signed [COORD_W-1:0] pick_coord();
    case ($urandom_range(0, 3))
      0: return $signed($urandom_range(0, 8)) - 4;
      1: begin
        case ($urandom_range(0, 3))
          0: return COORD_MIN;
          1: return COORD_MAX;
          2: return 0;
          default: return -1;
        endcase
      end
      default: return $urandom;
    endcase
  endfunction

  // Offers one request beat and waits until it is taken.
  task automatic send_beat(input func_e op, input logic signed [COORD_W-1:0] px,
                           input logic signed [COORD_W-1:0] py);
    int unsigned gap;
    gap = draw_gap(send_burst);
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_ch.valid   <= 1'b1;
    in_ch.func    <= op;
    in_ch.point_x <= px;
    in_ch.point_y <= py;
    do @(posedge clk_i); while (!in_ch.ready);
    @(negedge clk_i);
    if (op == FUNC_INSERT) begin
      if (heap_fill < HEAP_DEPTH) heap_fill++;
    end else if (heap_fill > 0) begin
      heap_fill--;
    end
  endtask

  task automatic send_random(input int unsigned insert_pct);
    func_e op;
    op = ($urandom_range(0, 99) < insert_pct) ? FUNC_INSERT : FUNC_EXTRACT;
    send_beat(op, pick_coord(), pick_coord());
  endtask

  // Stops offering and waits until every predicted result has been read.
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    do @(negedge clk_i); while (results_owed != 0);
  endtask

  // Result side: random stalls, plus two long hold-offs that back the block up.
  initial begin : result_sink
    int unsigned gap;
    int unsigned beats_taken;
    out_ch.ready = 1'b0;
    beats_taken  = 0;
    sink_burst   = 0;
    do @(negedge clk_i); while (!rst_ni);
    forever begin
      if (beats_taken == 150 || beats_taken == 1300) gap = 400;
      else gap = draw_gap(sink_burst);
      if (gap != 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk_i); while (!out_ch.valid);
      beats_taken++;
      @(negedge clk_i);
    end
  end

  // Request side and verdict.
  initial begin : request_source
    in_ch.valid   = 1'b0;
    in_ch.func    = FUNC_INSERT;
    in_ch.point_x = '0;
    in_ch.point_y = '0;
    rst_ni        = 1'b0;
    heap_fill     = 0;
    send_burst    = 0;
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed: empty extract, extreme corners, sign boundaries and equal points.
    send_beat(FUNC_EXTRACT, 0, 0);
    send_beat(FUNC_INSERT, 0, 0);
    send_beat(FUNC_INSERT, COORD_MAX, COORD_MAX);
    send_beat(FUNC_INSERT, COORD_MIN, COORD_MIN);
    send_beat(FUNC_INSERT, COORD_MIN, COORD_MAX);
    send_beat(FUNC_INSERT, COORD_MAX, COORD_MIN);
    send_beat(FUNC_INSERT, -1, -1);
    send_beat(FUNC_INSERT, 0, 0);
    send_beat(FUNC_INSERT, 5, -3);
    send_beat(FUNC_INSERT, 5, 7);
    send_beat(FUNC_INSERT, 5, -3);
    send_beat(FUNC_INSERT, -1, 0);
    repeat (11) send_beat(FUNC_EXTRACT, 0, 0);
    send_beat(FUNC_EXTRACT, 0, 0);

    // Mixed traffic at a low fill level.
    repeat (200) send_random(55);
    wait_drained();

    // Fill to capacity, then push against the full heap.
    while (heap_fill < HEAP_DEPTH) send_random(97);
    repeat (12) send_beat(FUNC_INSERT, pick_coord(), pick_coord());
    repeat (150) send_random(50);
    wait_drained();

    // Mostly extracts from a nearly full heap for deep sift-downs.
    repeat (60) send_random(10);

    wait_drained();
    repeat (50) @(negedge clk_i);
    if (mismatch_count == 0 && results_owed == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
